>>> src/tpc_pkg.sv
package tpc_pkg;

   localparam int unsigned TICK_WIDTH = 32;
   localparam int unsigned CSR_WIDTH  = 16;
   localparam int unsigned MODE_WIDTH = 3;

   localparam int unsigned FAST_BLINK_HALF = 100;
   localparam int unsigned SLOW_BLINK_HALF = 300;

   localparam logic [2:0] CSR_DEBOUNCE    = 3'd0;
   localparam logic [2:0] CSR_COMBO_HOLD  = 3'd1;
   localparam logic [2:0] CSR_POWER_HOLD  = 3'd2;
   localparam logic [2:0] CSR_MODE_HOLD   = 3'd3;
   localparam logic [2:0] CSR_UPDATE_HOLD = 3'd4;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_TOGGLE = 2'd1;
   localparam logic [1:0] EVT_MODE   = 2'd2;
   localparam logic [1:0] EVT_UPDATE = 2'd3;

   typedef struct packed {
      logic task_level;
      logic power_level;
   } req_type;

   typedef struct packed {
      logic                  working;
      logic [MODE_WIDTH-1:0] source_mode;
      logic [1:0]            task_event;
      logic                  config_request;
      logic                  power_off_request;
      logic                  task_led;
   } rsp_type;

   typedef struct packed {
      logic [CSR_WIDTH-1:0] debounce_ms;
      logic [CSR_WIDTH-1:0] combo_hold_ms;
      logic [CSR_WIDTH-1:0] power_hold_ms;
      logic [CSR_WIDTH-1:0] mode_hold_ms;
      logic [CSR_WIDTH-1:0] update_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic step;
      logic wrap;
   } tick_ctl_type;

   typedef struct packed {
      logic fast;
      logic slow;
   } blink_phase_type;

endpackage

>>> src/tpc_csr.sv
module tpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          write_enable,
   input  logic [2:0]                    index,
   input  logic [tpc_pkg::CSR_WIDTH-1:0] write_data,
   output tpc_pkg::cfg_type              cfg
);
   import tpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_enable) begin
         case (index)
            CSR_DEBOUNCE:    cfg_in.debounce_ms    = write_data;
            CSR_COMBO_HOLD:  cfg_in.combo_hold_ms  = write_data;
            CSR_POWER_HOLD:  cfg_in.power_hold_ms  = write_data;
            CSR_MODE_HOLD:   cfg_in.mode_hold_ms   = write_data;
            CSR_UPDATE_HOLD: cfg_in.update_hold_ms = write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms    <= CSR_WIDTH'(50);
         cfg_ff.combo_hold_ms  <= CSR_WIDTH'(5000);
         cfg_ff.power_hold_ms  <= CSR_WIDTH'(3000);
         cfg_ff.mode_hold_ms   <= CSR_WIDTH'(3000);
         cfg_ff.update_hold_ms <= CSR_WIDTH'(10000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/tpc_blink.sv
module tpc_blink (
   input  logic                     clock,
   input  logic                     reset,
   input  tpc_pkg::tick_ctl_type    tick_ctl,
   output tpc_pkg::blink_phase_type phase
);
   import tpc_pkg::*;

   // The counters track the tick count modulo each half period, so the phase
   // bits equal bit 0 of the tick count divided by the half period.
   localparam int unsigned FAST_W = $clog2(FAST_BLINK_HALF);
   localparam int unsigned SLOW_W = $clog2(SLOW_BLINK_HALF);

   logic [FAST_W-1:0] fast_cnt_ff, fast_cnt_in;
   logic [SLOW_W-1:0] slow_cnt_ff, slow_cnt_in;
   logic              fast_bit_ff, fast_bit_in;
   logic              slow_bit_ff, slow_bit_in;

   always_comb begin
      if (tick_ctl.wrap) begin
         fast_cnt_in = '0;
         fast_bit_in = 1'b0;
         slow_cnt_in = '0;
         slow_bit_in = 1'b0;
      end else begin
         if (fast_cnt_ff == FAST_W'(FAST_BLINK_HALF - 1)) begin
            fast_cnt_in = '0;
            fast_bit_in = !fast_bit_ff;
         end else begin
            fast_cnt_in = fast_cnt_ff + FAST_W'(1);
            fast_bit_in = fast_bit_ff;
         end
         if (slow_cnt_ff == SLOW_W'(SLOW_BLINK_HALF - 1)) begin
            slow_cnt_in = '0;
            slow_bit_in = !slow_bit_ff;
         end else begin
            slow_cnt_in = slow_cnt_ff + SLOW_W'(1);
            slow_bit_in = slow_bit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_cnt_ff <= '0;
         fast_bit_ff <= 1'b0;
         slow_cnt_ff <= '0;
         slow_bit_ff <= 1'b0;
      end else if (tick_ctl.step) begin
         fast_cnt_ff <= fast_cnt_in;
         fast_bit_ff <= fast_bit_in;
         slow_cnt_ff <= slow_cnt_in;
         slow_bit_ff <= slow_bit_in;
      end
   end

   assign phase.fast = fast_bit_in;
   assign phase.slow = slow_bit_in;

endmodule

>>> src/tpc_core.sv
module tpc_core #(
   parameter int unsigned MODE_COUNT = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  tpc_pkg::req_type         item,
   input  tpc_pkg::cfg_type         cfg,
   input  tpc_pkg::blink_phase_type phase,
   output tpc_pkg::tick_ctl_type    tick_ctl,
   output tpc_pkg::rsp_type         result
);
   import tpc_pkg::*;

   logic [TICK_WIDTH-1:0] tick_ff, task_change_ff, task_press_ff, power_press_ff, combo_start_ff;
   logic [TICK_WIDTH-1:0] task_change_in, task_press_in, power_press_in, combo_start_in;
   logic                  prev_task_ff, task_stable_ff, prev_power_ff, power_fired_ff;
   logic                  task_stable_in, power_fired_in;
   logic                  combo_running_ff, combo_handled_ff, working_ff, led_ff;
   logic                  combo_running_in, combo_handled_in, working_in, led_in;
   logic [MODE_WIDTH-1:0] mode_ff, mode_in;

   logic [TICK_WIDTH-1:0] now, start_eff, task_hold, led_hold;
   logic                  task_bit, power_bit, cfg_req, off_req;
   logic [1:0]            event_code;

   assign now       = tick_ff + TICK_WIDTH'(1);
   assign task_bit  = item.task_level;
   assign power_bit = item.power_level;
   assign start_eff = combo_running_ff ? combo_start_ff : now;

   always_comb begin
      combo_running_in = combo_running_ff;
      combo_start_in   = combo_start_ff;
      combo_handled_in = combo_handled_ff;
      power_press_in   = power_press_ff;
      power_fired_in   = power_fired_ff;
      task_press_in    = task_press_ff;
      task_change_in   = task_change_ff;
      task_stable_in   = task_stable_ff;
      working_in       = working_ff;
      mode_in          = mode_ff;
      led_in           = led_ff;
      cfg_req          = 1'b0;
      off_req          = 1'b0;
      event_code       = EVT_NONE;

      if (!task_bit && !power_bit) begin
         combo_running_in = 1'b1;
         combo_start_in   = start_eff;
         if ((now - start_eff) > TICK_WIDTH'(cfg.combo_hold_ms) && !combo_handled_ff) begin
            combo_handled_in = 1'b1;
            cfg_req          = 1'b1;
            power_press_in   = now;
            task_press_in    = now;
         end
      end else begin
         combo_running_in = 1'b0;
         if (task_bit && power_bit) begin
            combo_handled_in = 1'b0;
         end
      end

      if (!power_bit && prev_power_ff) begin
         power_press_in = now;
         power_fired_in = 1'b0;
      end
      if (!power_bit && !prev_power_ff && task_bit && !combo_handled_in && !power_fired_ff
          && (now - power_press_in) > TICK_WIDTH'(cfg.power_hold_ms)) begin
         power_fired_in = 1'b1;
         off_req        = 1'b1;
      end

      task_hold = now - task_press_in;
      if (task_bit != prev_task_ff) begin
         task_change_in = now;
      end
      if ((now - task_change_in) > TICK_WIDTH'(cfg.debounce_ms)
          && task_bit != task_stable_ff) begin
         task_stable_in = task_bit;
         if (!task_bit) begin
            task_press_in = now;
         end else if (!combo_handled_in) begin
            if (task_hold >= TICK_WIDTH'(cfg.update_hold_ms)) begin
               event_code = EVT_UPDATE;
            end else if (task_hold >= TICK_WIDTH'(cfg.mode_hold_ms)) begin
               mode_in    = (mode_ff == MODE_WIDTH'(MODE_COUNT - 1)) ? '0
                                                                     : mode_ff + MODE_WIDTH'(1);
               event_code = EVT_MODE;
            end else begin
               working_in = !working_ff;
               event_code = EVT_TOGGLE;
            end
         end
      end

      led_hold = now - task_press_in;
      if (!task_stable_in && !combo_handled_in) begin
         if (led_hold >= TICK_WIDTH'(cfg.update_hold_ms)) begin
            led_in = !phase.fast;
         end else if (led_hold >= TICK_WIDTH'(cfg.mode_hold_ms)) begin
            led_in = !phase.slow;
         end
      end else begin
         led_in = working_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff          <= '0;
         prev_task_ff     <= 1'b1;
         task_stable_ff   <= 1'b1;
         task_change_ff   <= '0;
         task_press_ff    <= '0;
         prev_power_ff    <= 1'b1;
         power_press_ff   <= '0;
         power_fired_ff   <= 1'b0;
         combo_running_ff <= 1'b0;
         combo_start_ff   <= '0;
         combo_handled_ff <= 1'b0;
         working_ff       <= 1'b0;
         mode_ff          <= MODE_WIDTH'(MODE_COUNT - 1);
         led_ff           <= 1'b0;
      end else if (step) begin
         tick_ff          <= now;
         prev_task_ff     <= task_bit;
         task_stable_ff   <= task_stable_in;
         task_change_ff   <= task_change_in;
         task_press_ff    <= task_press_in;
         prev_power_ff    <= power_bit;
         power_press_ff   <= power_press_in;
         power_fired_ff   <= power_fired_in;
         combo_running_ff <= combo_running_in;
         combo_start_ff   <= combo_start_in;
         combo_handled_ff <= combo_handled_in;
         working_ff       <= working_in;
         mode_ff          <= mode_in;
         led_ff           <= led_in;
      end
   end

   assign tick_ctl.step = step;
   assign tick_ctl.wrap = (tick_ff == '1);

   assign result.working           = working_in;
   assign result.source_mode       = mode_in;
   assign result.task_event        = event_code;
   assign result.config_request    = cfg_req;
   assign result.power_off_request = off_req;
   assign result.task_led          = led_in;

endmodule

>>> src/two_button_press_classifier_unit.sv
// Two-button press classifier. Each input transfer is one millisecond tick carrying the raw
// active-low levels of the task and power buttons, and each tick produces exactly one result
// transfer with the working flag, the mode, the task event, the configuration and power-off
// request pulses and the task LED level. One tick is accepted every clock cycle while
// req_stall is low. A tick passes through the input register, then the result register;
// rsp_stall can hold it in either, and all state updates for a tick happen as it moves
// between them. Hold thresholds are written through the csr_ port, by register index; the
// user must write them only while no tick is in flight, which the block does not enforce.
// The input stall rises only when both registers are full and rsp_stall is high.
module two_button_press_classifier_unit #(
   parameter int unsigned MODE_COUNT = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tpc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tpc_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_enable,
   input  logic [2:0]                    csr_index,
   input  logic [tpc_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import tpc_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff;
   logic            accept, advance;
   cfg_type         cfg;
   tick_ctl_type    tick_ctl;
   blink_phase_type phase;
   rsp_type         result;

   assign advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept       = req_valid && !req_stall;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   tpc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .write_enable (csr_write_enable),
      .index        (csr_index),
      .write_data   (csr_write_data),
      .cfg          (cfg)
   );

   tpc_blink u_blink (
      .clock    (clock),
      .reset    (reset),
      .tick_ctl (tick_ctl),
      .phase    (phase)
   );

   tpc_core #(
      .MODE_COUNT (MODE_COUNT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_data_ff),
      .cfg      (cfg),
      .phase    (phase),
      .tick_ctl (tick_ctl),
      .result   (result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

>>> src/tpc_checker.sv
module tpc_checker #(
   parameter int unsigned MODE_COUNT = 5
) (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tpc_pkg::rsp_type rsp_data
);
   import tpc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.source_mode <= MODE_WIDTH'(MODE_COUNT - 1))
      else $error("mode out of range");

   a_req_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.config_request && rsp_data.power_off_request))
      else $error("config and power-off requests in the same tick");

   a_event_vs_combo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.config_request |-> rsp_data.task_event == EVT_NONE)
      else $error("task event together with a combo request");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind two_button_press_classifier_unit tpc_checker #(
   .MODE_COUNT (MODE_COUNT)
) u_tpc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
